### design/weighted_length_table_sampler_core_defines.svh
// Assertion macros used by the weighted length table sampler top level.
`ifndef WEIGHTED_LENGTH_TABLE_SAMPLER_CORE_DEFINES_SVH
`define WEIGHTED_LENGTH_TABLE_SAMPLER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define WLTS_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

// Next-cycle implication, disabled while reset is high.
`define WLTS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

### design/wlts_pkg.sv
// Package with the constants, word types and control types of the sampler.
`timescale 1ns / 1ps

package wlts_pkg;

   localparam int MAX_PAIRS  = 256;
   localparam int TABLE_SIZE = 1024;

   localparam int ACTION_W = 2;
   localparam int WEIGHT_W = 16;
   localparam int LENGTH_W = 16;
   localparam int RANDOM_W = 32;
   localparam int STATUS_W = 2;
   localparam int TOTAL_W  = 24;

   localparam int FILL_W     = $clog2(TABLE_SIZE + 1);
   localparam int QUOT_W     = FILL_W;
   localparam int DIVIDEND_W = WEIGHT_W + QUOT_W;
   localparam int SLOT_IDX_W = $clog2(TABLE_SIZE);
   localparam int PAIR_IDX_W = (MAX_PAIRS > 1) ? $clog2(MAX_PAIRS) : 1;
   localparam int PAIR_CNT_W = $clog2(MAX_PAIRS + 1);

   localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

   localparam logic [ACTION_W-1:0] ACT_LOAD   = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_BUILD  = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_SAMPLE = 2'd2;

   localparam logic [STATUS_W-1:0] STATUS_OK         = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_LIST_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY      = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_ZERO_TOTAL = 2'd3;

   typedef struct packed {
      logic [ACTION_W-1:0] action;
      logic [WEIGHT_W-1:0] weight;
      logic [LENGTH_W-1:0] pkt_length;
      logic [RANDOM_W-1:0] random_word;
   } req_word_type;

   typedef struct packed {
      logic [LENGTH_W-1:0] sampled_length;
      logic [LENGTH_W-1:0] longest_length;
      logic [FILL_W-1:0]   table_fill;
      logic [STATUS_W-1:0] status;
   } rsp_word_type;

   typedef struct packed {
      logic capture;
      logic load;
      logic smp_mul;
      logic smp_read;
      logic bld_start;
      logic bld_read;
      logic div_start;
      logic fill_step;
      logic pair_next;
      logic emit;
   } ctrl_cmd_type;

   typedef struct packed {
      logic [ACTION_W-1:0] action;
      logic                total_zero;
      logic                pairs_done;
      logic                fill_done;
      logic                div_idle;
   } dp_status_type;

endpackage

### design/wlts_div.sv
// Restoring divider that yields one quotient bit per cycle for the slot counts.
`timescale 1ns / 1ps

module wlts_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [wlts_pkg::DIVIDEND_W-1:0] dividend,
   input  logic [wlts_pkg::TOTAL_W-1:0]    divisor,
   output logic [wlts_pkg::QUOT_W-1:0]     quotient,
   output logic                          idle
);
   import wlts_pkg::*;

   localparam int CNT_W = $clog2(QUOT_W + 1);

   logic [TOTAL_W-1:0] rem_ff;
   logic [QUOT_W-1:0]  shift_ff;
   logic [CNT_W-1:0]   count_ff;
   logic               run_ff;
   logic [TOTAL_W:0]   trial;
   logic [TOTAL_W:0]   diff;
   logic               fits;

   assign trial = {rem_ff, shift_ff[QUOT_W-1]};
   assign fits  = trial >= {1'b0, divisor};
   assign diff  = trial - {1'b0, divisor};

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff   <= 1'b0;
         count_ff <= '0;
      end else if (start) begin
         run_ff   <= 1'b1;
         count_ff <= CNT_W'(QUOT_W);
      end else if (run_ff) begin
         count_ff <= count_ff - CNT_W'(1);
         run_ff   <= count_ff != CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff   <= TOTAL_W'(dividend[DIVIDEND_W-1:QUOT_W]);
         shift_ff <= dividend[QUOT_W-1:0];
      end else if (run_ff) begin
         rem_ff   <= fits ? diff[TOTAL_W-1:0] : trial[TOTAL_W-1:0];
         shift_ff <= {shift_ff[QUOT_W-2:0], fits};
      end
   end

   assign quotient = shift_ff;
   assign idle     = !run_ff;

endmodule

### design/wlts_datapath.sv
// Datapath of the sampler: pair list, slot table, running totals and response word.
`timescale 1ns / 1ps

module wlts_datapath (
   input  logic                    clock,
   input  logic                    reset,
   input  wlts_pkg::ctrl_cmd_type  cmd,
   input  wlts_pkg::req_word_type  req_word,
   output wlts_pkg::dp_status_type status_out,
   output wlts_pkg::rsp_word_type  rsp_word
);
   import wlts_pkg::*;

   logic [WEIGHT_W-1:0] weight_mem [MAX_PAIRS];
   logic [LENGTH_W-1:0] length_mem [MAX_PAIRS];
   logic [LENGTH_W-1:0] slot_mem   [TABLE_SIZE];

   req_word_type        req_ff;
   rsp_word_type        rsp_ff;
   logic [PAIR_CNT_W-1:0] pair_count_ff;
   logic [TOTAL_W-1:0]  total_ff;
   logic [LENGTH_W-1:0] max_len_ff;
   logic [FILL_W-1:0]   slots_filled_ff;
   logic                table_ready_ff;
   logic [PAIR_CNT_W-1:0] pair_idx_ff;
   logic [QUOT_W-1:0]   k_ff;
   logic [STATUS_W-1:0] status_ff;
   logic                hit_ff;
   logic [SLOT_IDX_W-1:0] idx_ff;
   logic [LENGTH_W-1:0] slot_rd_ff;
   logic [WEIGHT_W-1:0] pair_w_ff;
   logic [LENGTH_W-1:0] pair_len_ff;

   logic [PAIR_CNT_W-1:0] base_count;
   logic [TOTAL_W-1:0]  base_total;
   logic [LENGTH_W-1:0] base_max;
   logic                list_full;
   logic [TOTAL_W:0]    sum_wide;
   logic [TOTAL_W-1:0]  sum_sat;
   logic [LENGTH_W-1:0] max_next;
   logic [FILL_W+RANDOM_W-1:0] product;
   logic [DIVIDEND_W-1:0] dividend;
   logic [QUOT_W-1:0]   quotient;
   logic                div_idle;
   logic                table_empty;

   // A load after a build starts a fresh list.
   assign base_count = table_ready_ff ? '0 : pair_count_ff;
   assign base_total = table_ready_ff ? '0 : total_ff;
   assign base_max   = table_ready_ff ? '0 : max_len_ff;
   assign list_full  = base_count == PAIR_CNT_W'(MAX_PAIRS);
   assign sum_wide   = {1'b0, base_total} + (TOTAL_W + 1)'(req_ff.weight);
   assign sum_sat    = (sum_wide > {1'b0, TOTAL_MAX}) ? TOTAL_MAX : sum_wide[TOTAL_W-1:0];
   assign max_next   = (req_ff.pkt_length > base_max) ? req_ff.pkt_length : base_max;

   assign product     = (FILL_W + RANDOM_W)'(slots_filled_ff) *
                        (FILL_W + RANDOM_W)'(req_ff.random_word);
   assign table_empty = !table_ready_ff || (slots_filled_ff == '0);
   assign dividend    = DIVIDEND_W'(pair_w_ff) * DIVIDEND_W'(TABLE_SIZE);

   wlts_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (dividend),
      .divisor  (total_ff),
      .quotient (quotient),
      .idle     (div_idle)
   );

   always_ff @(posedge clock) begin
      if (cmd.load && !list_full) begin
         weight_mem[base_count[PAIR_IDX_W-1:0]] <= req_ff.weight;
         length_mem[base_count[PAIR_IDX_W-1:0]] <= req_ff.pkt_length;
      end
      if (cmd.bld_read) begin
         pair_w_ff   <= weight_mem[pair_idx_ff[PAIR_IDX_W-1:0]];
         pair_len_ff <= length_mem[pair_idx_ff[PAIR_IDX_W-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.fill_step) begin
         slot_mem[slots_filled_ff[SLOT_IDX_W-1:0]] <= pair_len_ff;
      end
      if (cmd.smp_read) begin
         slot_rd_ff <= slot_mem[idx_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pair_count_ff   <= '0;
         total_ff        <= '0;
         max_len_ff      <= '0;
         slots_filled_ff <= '0;
         table_ready_ff  <= 1'b0;
         pair_idx_ff     <= '0;
         k_ff            <= '0;
      end else begin
         if (cmd.load) begin
            table_ready_ff <= 1'b0;
            pair_count_ff  <= list_full ? base_count : base_count + PAIR_CNT_W'(1);
            total_ff       <= list_full ? base_total : sum_sat;
            max_len_ff     <= list_full ? base_max : max_next;
         end
         if (cmd.bld_start) begin
            table_ready_ff  <= 1'b1;
            slots_filled_ff <= '0;
            pair_idx_ff     <= '0;
         end
         if (cmd.div_start) begin
            k_ff <= '0;
         end
         if (cmd.fill_step) begin
            slots_filled_ff <= slots_filled_ff + FILL_W'(1);
            k_ff            <= k_ff + QUOT_W'(1);
         end
         if (cmd.pair_next) begin
            pair_idx_ff <= pair_idx_ff + PAIR_CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_ff    <= req_word;
         status_ff <= STATUS_OK;
         hit_ff    <= 1'b0;
      end
      if (cmd.load) begin
         status_ff <= list_full ? STATUS_LIST_FULL : STATUS_OK;
      end
      if (cmd.smp_mul) begin
         idx_ff    <= product[RANDOM_W +: SLOT_IDX_W];
         hit_ff    <= !table_empty;
         status_ff <= table_empty ? STATUS_EMPTY : STATUS_OK;
      end
      if (cmd.bld_start) begin
         status_ff <= (total_ff == '0) ? STATUS_ZERO_TOTAL : STATUS_OK;
      end
      if (cmd.emit) begin
         rsp_ff.sampled_length <= hit_ff ? slot_rd_ff : '0;
         rsp_ff.longest_length <= max_len_ff;
         rsp_ff.table_fill     <= slots_filled_ff;
         rsp_ff.status         <= status_ff;
      end
   end

   assign status_out.action     = req_ff.action;
   assign status_out.total_zero = total_ff == '0;
   assign status_out.pairs_done = pair_idx_ff == pair_count_ff;
   assign status_out.fill_done  = (k_ff == quotient) ||
                                  (slots_filled_ff == FILL_W'(TABLE_SIZE));
   assign status_out.div_idle   = div_idle;
   assign rsp_word              = rsp_ff;

endmodule

### design/wlts_ctrl.sv
// Controller state machine that sequences loads, builds and samples.
`timescale 1ns / 1ps

module wlts_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   output logic                    rsp_strobe,
   input  wlts_pkg::dp_status_type status_in,
   output wlts_pkg::ctrl_cmd_type  cmd
);
   import wlts_pkg::*;

   localparam logic [3:0] S_IDLE         = 4'd0;
   localparam logic [3:0] S_DECODE       = 4'd1;
   localparam logic [3:0] S_LOAD         = 4'd2;
   localparam logic [3:0] S_SMP_MUL      = 4'd3;
   localparam logic [3:0] S_SMP_READ     = 4'd4;
   localparam logic [3:0] S_BLD_START    = 4'd5;
   localparam logic [3:0] S_BLD_READ     = 4'd6;
   localparam logic [3:0] S_BLD_DIV_LOAD = 4'd7;
   localparam logic [3:0] S_BLD_DIV      = 4'd8;
   localparam logic [3:0] S_BLD_FILL     = 4'd9;
   localparam logic [3:0] S_EMIT         = 4'd10;

   logic [3:0] state_ff;
   logic [3:0] state_in;
   logic       strobe_ff;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.capture = 1'b1;
               state_in    = S_DECODE;
            end
         end
         S_DECODE: begin
            unique case (status_in.action)
               ACT_LOAD:   state_in = S_LOAD;
               ACT_BUILD:  state_in = S_BLD_START;
               ACT_SAMPLE: state_in = S_SMP_MUL;
               default:    state_in = S_EMIT;
            endcase
         end
         S_LOAD: begin
            cmd.load = 1'b1;
            state_in = S_EMIT;
         end
         S_SMP_MUL: begin
            cmd.smp_mul = 1'b1;
            state_in    = S_SMP_READ;
         end
         S_SMP_READ: begin
            cmd.smp_read = 1'b1;
            state_in     = S_EMIT;
         end
         S_BLD_START: begin
            cmd.bld_start = 1'b1;
            state_in      = status_in.total_zero ? S_EMIT : S_BLD_READ;
         end
         S_BLD_READ: begin
            if (status_in.pairs_done) begin
               state_in = S_EMIT;
            end else begin
               cmd.bld_read = 1'b1;
               state_in     = S_BLD_DIV_LOAD;
            end
         end
         S_BLD_DIV_LOAD: begin
            cmd.div_start = 1'b1;
            state_in      = S_BLD_DIV;
         end
         S_BLD_DIV: begin
            if (status_in.div_idle) begin
               state_in = S_BLD_FILL;
            end
         end
         S_BLD_FILL: begin
            if (status_in.fill_done) begin
               cmd.pair_next = 1'b1;
               state_in      = S_BLD_READ;
            end else begin
               cmd.fill_step = 1'b1;
            end
         end
         S_EMIT: begin
            cmd.emit = 1'b1;
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= state_ff == S_EMIT;
      end
   end

   assign busy       = state_ff != S_IDLE;
   assign rsp_strobe = strobe_ff;

endmodule

### design/weighted_length_table_sampler_core.sv
// Top level of the weighted packet-length sampler.
//
// Request words enter on req_word and are taken at a rising edge with start high
// and busy low. Each request gives exactly one response word on rsp_word, shown
// for one cycle with rsp_strobe high; the receiver must take it then.
// A load passes through the decode, load and emit states, a sample through
// decode, multiply, read and emit, and an unused action through decode and
// emit; busy is already low while the strobe is up, so the next request can
// be taken in the strobe cycle. A build's duration is set by the restoring
// divider (one quotient bit a cycle) that works out each pair's slot count,
// and by the single table write port. The sample index comes from one 11 by
// 32 bit multiply, then a registered read of the slot table.
// A synchronous reset empties the pair list, marks the table unbuilt and drops
// any request in flight; the table contents themselves are left as they are.
`timescale 1ns / 1ps
`include "weighted_length_table_sampler_core_defines.svh"

module weighted_length_table_sampler_core (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  wlts_pkg::req_word_type req_word,
   output logic                   rsp_strobe,
   output wlts_pkg::rsp_word_type rsp_word
);
   import wlts_pkg::*;

   ctrl_cmd_type  cmd;
   dp_status_type dp_status;
   logic          rsp_failed;

   assign rsp_failed = rsp_strobe && (rsp_word.status != STATUS_OK);

   wlts_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .rsp_strobe (rsp_strobe),
      .status_in  (dp_status),
      .cmd        (cmd)
   );

   wlts_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .req_word   (req_word),
      .status_out (dp_status),
      .rsp_word   (rsp_word)
   );

   `WLTS_ASSERT_NEXT(a_strobe_single, clock, reset, rsp_strobe, !rsp_strobe)
   `WLTS_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy)
   `WLTS_ASSERT_IMPLY(a_strobe_idle, clock, reset, rsp_strobe, !busy)
   `WLTS_ASSERT_IMPLY(a_fail_no_length, clock, reset, rsp_failed, rsp_word.sampled_length == '0)

endmodule

### bench/weighted_length_table_sampler_core_tb.sv
// Self-checking testbench for the weighted packet-length table sampler core.
`timescale 1ns / 1ps

module weighted_length_table_sampler_core_tb;
   import wlts_pkg::*;

   localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;
   localparam int CYCLE_LIMIT = 1_000_000;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         start = 1'b0;
   logic         busy;
   req_word_type req_word = '0;
   logic         rsp_strobe;
   rsp_word_type rsp_word;

   logic [WEIGHT_W-1:0]   pair_weight [MAX_PAIRS];
   logic [LENGTH_W-1:0]   pair_length [MAX_PAIRS];
   logic [PAIR_CNT_W-1:0] pairs_loaded = '0;
   logic [TOTAL_W-1:0]    weight_sum = '0;
   logic [LENGTH_W-1:0]   longest_seen = '0;
   logic [LENGTH_W-1:0]   slot_length [TABLE_SIZE];
   logic [FILL_W-1:0]     slots_used = '0;
   logic                  table_built = 1'b0;

   rsp_word_type predicted_words[$];
   int error_count = 0;
   int words_sent = 0;
   bit gaps_on = 1'b1;

   weighted_length_table_sampler_core dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_word   (req_word),
      .rsp_strobe (rsp_strobe),
      .rsp_word   (rsp_word)
   );

   always #10 clock = ~clock;

   function automatic rsp_word_type predict_response(req_word_type w);
      rsp_word_type r;
      logic [TOTAL_W:0] sum;
      logic [63:0] share;
      logic [63:0] product;
      logic [63:0] idx;
      int fill;
      r = '0;
      case (w.action)
         ACT_LOAD: begin
            if (table_built) begin
               pairs_loaded = '0;
               weight_sum = '0;
               longest_seen = '0;
               table_built = 1'b0;
            end
            if (pairs_loaded >= MAX_PAIRS) begin
               r.status = STATUS_LIST_FULL;
            end else begin
               pair_weight[pairs_loaded] = w.weight;
               pair_length[pairs_loaded] = w.pkt_length;
               pairs_loaded = pairs_loaded + 1'b1;
               sum = weight_sum + w.weight;
               weight_sum = (sum > TOTAL_MAX) ? TOTAL_MAX : sum[TOTAL_W-1:0];
               if (w.pkt_length > longest_seen) longest_seen = w.pkt_length;
            end
         end
         ACT_BUILD: begin
            table_built = 1'b1;
            if (weight_sum == 0) begin
               slots_used = '0;
               r.status = STATUS_ZERO_TOTAL;
            end else begin
               fill = 0;
               for (int i = 0; i < pairs_loaded; i++) begin
                  share = (64'(pair_weight[i]) * 64'(TABLE_SIZE)) / 64'(weight_sum);
                  for (longint k = 0; k < share && fill < TABLE_SIZE; k++) begin
                     slot_length[fill] = pair_length[i];
                     fill++;
                  end
               end
               slots_used = FILL_W'(fill);
            end
         end
         ACT_SAMPLE: begin
            if (!table_built || slots_used == 0) begin
               r.status = STATUS_EMPTY;
            end else begin
               product = 64'(slots_used) * 64'(w.random_word);
               idx = product >> 32;
               if (idx >= TABLE_SIZE) idx = TABLE_SIZE - 1;
               r.sampled_length = slot_length[idx];
            end
         end
         default: ;
      endcase
      r.longest_length = longest_seen;
      r.table_fill = slots_used;
      return r;
   endfunction

   function automatic void check_field(string name, longint want, longint got);
      if (want != got) begin
         error_count++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
   endfunction

   always @(posedge clock) begin
      rsp_word_type want;
      if (!reset && rsp_strobe) begin
         if (predicted_words.size() == 0) begin
            error_count++;
            $display("%0t: unexpected response word, expected none, actual %h",
                     $time, rsp_word);
         end else begin
            want = predicted_words.pop_front();
            check_field("sampled_length", want.sampled_length, rsp_word.sampled_length);
            check_field("longest_length", want.longest_length, rsp_word.longest_length);
            check_field("table_fill", want.table_fill, rsp_word.table_fill);
            check_field("status", want.status, rsp_word.status);
         end
      end
   end

   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("weighted_length_table_sampler_core_tb: errors");
      $finish;
   end

   task automatic idle_for(int cycles);
      start <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   task automatic send_word(logic [ACTION_W-1:0] act, logic [WEIGHT_W-1:0] weight,
                            logic [LENGTH_W-1:0] len, logic [RANDOM_W-1:0] rnd);
      req_word_type w;
      w = '{action: act, weight: weight, pkt_length: len, random_word: rnd};
      req_word <= w;
      start <= 1'b1;
      do @(posedge clock); while (busy);
      predicted_words.push_back(predict_response(w));
      words_sent++;
      if (gaps_on && $urandom_range(0, 5) == 0) idle_for($urandom_range(1, 15));
   endtask

   function automatic logic [WEIGHT_W-1:0] pick_weight(int mode);
      case (mode)
         0: return 16'($urandom);
         1: return 16'($urandom_range(0, 7));
         default: return ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 2))
                                                     : 16'($urandom);
      endcase
   endfunction

   function automatic logic [RANDOM_W-1:0] pick_random_word();
      case ($urandom_range(0, 19))
         0: return '0;
         1: return '1;
         default: return $urandom;
      endcase
   endfunction

   task automatic load_build_sample(int pairs, int draws);
      int mode;
      mode = $urandom_range(0, 2);
      for (int i = 0; i < pairs; i++)
         send_word(ACT_LOAD, pick_weight(mode), 16'($urandom), $urandom);
      send_word(ACT_BUILD, 16'($urandom), 16'($urandom), $urandom);
      for (int i = 0; i < draws; i++)
         send_word(ACT_SAMPLE, 16'($urandom), 16'($urandom), pick_random_word());
   endtask

   task automatic stray_word();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 40)
         send_word(ACT_SAMPLE, 16'($urandom), 16'($urandom), pick_random_word());
      else if (pick < 70)
         send_word(ACT_LOAD, pick_weight(2), 16'($urandom), $urandom);
      else if (pick < 85)
         send_word(ACT_UNUSED, 16'($urandom), 16'($urandom), $urandom);
      else
         send_word(ACT_BUILD, 16'($urandom), 16'($urandom), $urandom);
   endtask

   task automatic test_unbuilt_table();
      send_word(ACT_SAMPLE, 16'hFFFF, 16'hFFFF, '1);
      send_word(ACT_UNUSED, '1, '1, '1);
      send_word(ACT_BUILD, '0, '0, '0);
      send_word(ACT_SAMPLE, '0, '0, 32'h8000_0000);
      send_word(ACT_LOAD, '0, 16'hFFFF, '0);
      send_word(ACT_BUILD, '0, '0, '0);
      send_word(ACT_SAMPLE, '0, '0, '1);
   endtask

   task automatic test_field_extremes();
      send_word(ACT_LOAD, 16'hFFFF, 16'h0000, '0);
      send_word(ACT_LOAD, 16'h0001, 16'hFFFF, '1);
      send_word(ACT_LOAD, 16'h0000, 16'd1234, '0);
      send_word(ACT_LOAD, 16'h8000, 16'h0001, '0);
      send_word(ACT_BUILD, '0, '0, '0);
      send_word(ACT_SAMPLE, '0, '0, 32'h0000_0000);
      send_word(ACT_SAMPLE, '1, '1, 32'hFFFF_FFFF);
      send_word(ACT_SAMPLE, '0, '0, 32'h8000_0000);
      send_word(ACT_SAMPLE, '0, '0, 32'h7FFF_FFFF);
      send_word(ACT_UNUSED, '0, '0, '0);
      send_word(ACT_LOAD, 16'hFFFF, 16'hFFFF, '1);
      send_word(ACT_BUILD, '1, '1, '1);
      send_word(ACT_SAMPLE, '0, '0, 32'hFFFF_FFFF);
      send_word(ACT_SAMPLE, '0, '0, 32'h0000_0000);
   endtask

   task automatic test_list_overflow();
      load_build_sample(MAX_PAIRS + 4, 6);
   endtask

   task automatic test_sender_pause();
      load_build_sample(3, 4);
      start <= 1'b0;
      while (predicted_words.size() != 0) @(posedge clock);
      load_build_sample(2, 3);
   endtask

   task automatic test_weighted_sequences(int target, bit allow_gaps);
      int pick;
      while (words_sent < target) begin
         gaps_on = allow_gaps && ($urandom_range(0, 3) != 0);
         pick = $urandom_range(0, 99);
         if (pick < 20) begin
            repeat ($urandom_range(1, 6)) stray_word();
         end else if (pick < 22) begin
            load_build_sample($urandom_range(200, MAX_PAIRS + 4), $urandom_range(1, 20));
         end else if (pick < 55) begin
            load_build_sample($urandom_range(1, 3), $urandom_range(1, 20));
         end else begin
            load_build_sample($urandom_range(4, 24), $urandom_range(1, 20));
         end
      end
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      test_unbuilt_table();
      test_field_extremes();
      test_list_overflow();
      test_sender_pause();
      test_weighted_sequences(1550, 1'b1);
      test_weighted_sequences(1700, 1'b0);
      start <= 1'b0;
      while (predicted_words.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (error_count == 0)
         $display("weighted_length_table_sampler_core_tb: clean");
      else
         $display("weighted_length_table_sampler_core_tb: errors");
      $finish;
   end

endmodule
